### rtl/fbaa_pkg.sv
// Package: shared types and constants for the fixed block arena allocator.
package fbaa_pkg;

    localparam int unsigned MAX_BLOCKS = 1024;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned SIZE_W   = 13;
    localparam int unsigned IDX_W    = 10;
    localparam int unsigned OFF_W    = 22;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned WIDX_W   = 4;
    localparam int unsigned BOFF_W   = 32;
    localparam int unsigned FCNT_W   = 7;
    localparam int unsigned BIT_W    = 6;

    localparam logic [0:0] REG_BLOCK_COUNT = 1'b0;
    localparam logic [0:0] REG_BLOCK_SIZE  = 1'b1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_QUERY = 2'd2,
        OP_SWEEP = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [WIDX_W-1:0]   group_sel;
        logic [WORD_W-1:0]   alive_mask;
        logic [BOFF_W-1:0]   byte_offset;
    } t_in_item;

    typedef struct packed {
        logic                success;
        logic [IDX_W-1:0]    block_index;
        logic [OFF_W-1:0]    block_offset;
        logic [WORD_W-1:0]   freed_mask;
        logic [FCNT_W-1:0]   free_total;
        logic                full_res;
        logic                empty_res;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ALLOC_RD,
        ST_ALLOC_WAIT,
        ST_ALLOC_MUL,
        ST_QUERY_MUL,
        ST_QUERY_DIV,
        ST_QUERY_CHK,
        ST_SWEEP_RD,
        ST_SWEEP_SCAN,
        ST_OUT
    } t_state;

    // Control from the sequencer to the shared multiply/divide unit
    typedef struct packed {
        logic                start_mul;
        logic                start_div;
    } t_mdu_ctrl;

    typedef struct packed {
        logic                busy;
        logic                done;
    } t_mdu_stat;

endpackage

### rtl/fbaa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module fbaa_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/fbaa_mdu.sv
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module fbaa_mdu
    import fbaa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mdu_ctrl           i_ctrl,
    input  logic [BOFF_W-1:0]   i_a,
    input  logic [SIZE_W-1:0]   i_b,
    output t_mdu_stat           o_stat,
    output logic [BOFF_W-1:0]   o_quot,
    output logic [SIZE_W-1:0]   o_rem,
    output logic [BOFF_W-1:0]   o_prod
);
    localparam int unsigned CNT_W = $clog2(BOFF_W + 1);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic               r_is_div, n_is_div;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [BOFF_W-1:0]  r_acc, n_acc;
    logic [SIZE_W-1:0]  r_rem, n_rem;
    logic [BOFF_W-1:0]  r_a, n_a;
    logic [SIZE_W-1:0]  r_b, n_b;
    logic [SIZE_W:0]    w_trial;
    logic [SIZE_W:0]    w_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_is_div <= n_is_div;
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_rem    <= n_rem;
        r_a      <= n_a;
        r_b      <= n_b;
    end

    // Multiply: shift multiplier bits (r_b) out LSB first, add shifted a.
    // Divide: shift dividend in MSB first, compare-subtract per step.
    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_is_div = r_is_div;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_a      = r_a;
        n_b      = r_b;
        w_trial  = {r_rem, r_a[BOFF_W-1]};
        w_sub    = w_trial - {1'b0, r_b};
        if (i_ctrl.start_mul) begin
            n_busy   = 1'b1;
            n_is_div = 1'b0;
            n_cnt    = CNT_W'(SIZE_W);
            n_acc    = '0;
            n_a      = i_a;
            n_b      = i_b;
        end else if (i_ctrl.start_div) begin
            n_busy   = 1'b1;
            n_is_div = 1'b1;
            n_cnt    = CNT_W'(BOFF_W);
            n_acc    = '0;
            n_rem    = '0;
            n_a      = i_a;
            n_b      = i_b;
        end else if (r_busy) begin
            if (r_is_div) begin
                n_a = {r_a[BOFF_W-2:0], 1'b0};
                // remainder stays below the divisor, so the top bit is zero
                if (w_trial >= {1'b0, r_b}) begin
                    n_rem = w_sub[SIZE_W-1:0];
                    n_acc = {r_acc[BOFF_W-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[SIZE_W-1:0];
                    n_acc = {r_acc[BOFF_W-2:0], 1'b0};
                end
            end else begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a = {r_a[BOFF_W-2:0], 1'b0};
                n_b = {1'b0, r_b[SIZE_W-1:1]};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_acc;
    assign o_prod      = r_acc;
    assign o_rem       = r_rem;

`ifndef NO_ASSERTIONS
    a_no_double_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.start_mul && i_ctrl.start_div))
        else $error("mul and div started together");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without prior busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !(i_ctrl.start_mul || i_ctrl.start_div))
        else $error("start while busy");
`endif
endmodule

### rtl/fixed_block_arena_allocator.sv
// Top level: fixed block arena allocator with bitmap, summary mask and free stack.
// Each transaction yields one result. Allocate uses the shared one-bit-per-cycle
// multiply/divide unit for 13 multiply steps unless the stack is empty; query uses
// it for 32 divide steps unless the size is zero or the offset lies outside the
// arena. Sweep pushes each freed index, at most one per cycle, through the
// free-stack RAM write port while the stack has room; init walks every block up
// to the configured count, one push per cycle.
// Only one transaction is in flight; the next is taken once the result register
// is empty or being drained. No clearing pass.
module fixed_block_arena_allocator
    import fbaa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);
    localparam int unsigned NUM_WORDS = MAX_BLOCKS / WORD_W;
    localparam int unsigned SP_W      = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W     = SP_W + 1;
    localparam int unsigned W_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    // Configuration
    logic [COUNT_W-1:0] r_block_count;
    logic [SIZE_W-1:0]  r_block_size;

    // State
    logic [WORD_W-1:0]  r_bitmap [NUM_WORDS];
    logic [CNT_W-1:0]   r_sp, n_sp;
    t_state             r_state, n_state;
    t_in_item           r_in, n_in;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [CNT_W-1:0]   r_walk, n_walk;
    logic [WORD_W-1:0]  r_fmask, n_fmask;
    logic [IDX_W-1:0]   r_idx, n_idx;

    // Bitmap update controls
    logic               w_bm_clear;
    logic               w_bm_set;
    logic               w_bm_and;
    logic [W_W-1:0]     w_bm_word;
    logic [WORD_W-1:0]  w_bm_bits;

    // Stack RAM
    logic               w_we;
    logic [SP_W-1:0]    w_waddr;
    logic [SP_W-1:0]    w_wdata;
    logic [SP_W-1:0]    w_raddr;
    logic [SP_W-1:0]    w_rdata;

    // Shared arithmetic
    t_mdu_ctrl          w_mdu_ctrl;
    t_mdu_stat          w_mdu_stat;
    logic [BOFF_W-1:0]  w_mdu_a;
    logic [BOFF_W-1:0]  w_quot;
    logic [SIZE_W-1:0]  w_rem;
    logic [BOFF_W-1:0]  w_prod;

    logic [CNT_W-1:0]   w_count;
    logic [WORD_W-1:0]  w_valid_mask;
    logic [COUNT_W+WIDX_W+BIT_W-1:0] w_base;
    logic [WORD_W-1:0]  w_cur_word;
    logic               w_word_ok;
    logic               w_any_use;
    logic [BOFF_W-1:0]  w_end;
    logic [IDX_W-1:0]   w_push_idx;

    // Effective count saturated at capacity
    assign w_count = (r_block_count > COUNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                            : CNT_W'(r_block_count);

    fbaa_ram #(.WIDTH(SP_W), .DEPTH(MAX_BLOCKS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fbaa_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mdu_ctrl),
        .i_a     (w_mdu_a),
        .i_b     (r_block_size),
        .o_stat  (w_mdu_stat),
        .o_quot  (w_quot),
        .o_rem   (w_rem),
        .o_prod  (w_prod)
    );

    // Configuration writes
    assign o_cfg_ready = (r_state == ST_IDLE);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= COUNT_W'(1024);
            r_block_size  <= SIZE_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_BLOCK_COUNT) begin
                r_block_count <= i_cfg_data[COUNT_W-1:0];
            end else begin
                r_block_size <= i_cfg_data;
            end
        end
    end

    // Bitmap registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_bm_clear) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_bitmap[k] <= '0;
            end
        end else if (w_bm_set) begin
            r_bitmap[w_bm_word] <= r_bitmap[w_bm_word] | w_bm_bits;
        end else if (w_bm_and) begin
            r_bitmap[w_bm_word] <= r_bitmap[w_bm_word] & ~w_bm_bits;
        end
    end

    always_comb begin
        w_any_use = 1'b0;
        for (int k = 0; k < NUM_WORDS; k++) begin
            w_any_use = w_any_use | (|r_bitmap[k]);
        end
    end

    // Bitmap word: the popped index while marking, else the swept group
    assign w_bm_word  = (r_state == ST_ALLOC_WAIT) ? W_W'(w_rdata >> BIT_W)
                                                   : W_W'(r_in.group_sel);

    // Sweep word helpers
    assign w_word_ok  = ({28'd0, r_in.group_sel} < NUM_WORDS);
    assign w_cur_word = w_word_ok ? r_bitmap[w_bm_word] : '0;
    assign w_base     = (COUNT_W+WIDX_W+BIT_W)'(r_in.group_sel) << BIT_W;
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            w_valid_mask[b] = ((COUNT_W+WIDX_W+BIT_W)'(w_count) >
                               (w_base + (COUNT_W+WIDX_W+BIT_W)'(b)));
        end
    end
    assign w_push_idx = IDX_W'(w_base) | IDX_W'(r_walk[BIT_W-1:0]);
    assign w_end      = BOFF_W'(w_count) * BOFF_W'(r_block_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
        r_in    <= n_in;
        r_out   <= n_out;
        r_walk  <= n_walk;
        r_fmask <= n_fmask;
        r_idx   <= n_idx;
    end

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_in        = r_in;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_walk      = r_walk;
        n_fmask     = r_fmask;
        n_idx       = r_idx;
        w_bm_clear  = 1'b0;
        w_bm_set    = 1'b0;
        w_bm_and    = 1'b0;
        w_bm_bits   = '0;
        w_we        = 1'b0;
        w_waddr     = r_sp[SP_W-1:0];
        w_wdata     = '0;
        w_raddr     = r_sp[SP_W-1:0];
        w_mdu_ctrl  = '0;
        w_mdu_a     = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_in   = i_in_data;
                    n_out  = '0;
                    n_walk = '0;
                    unique case (i_in_data.opcode)
                        OP_INIT: begin
                            w_bm_clear = 1'b1;
                            n_sp       = '0;
                            n_state    = ST_INIT;
                        end
                        OP_ALLOC: begin
                            n_state = ST_ALLOC_RD;
                        end
                        OP_QUERY: begin
                            n_state = ST_QUERY_MUL;
                        end
                        OP_SWEEP: begin
                            n_state = ST_SWEEP_RD;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_INIT: begin
                if (r_walk < w_count) begin
                    w_we    = 1'b1;
                    w_waddr = r_walk[SP_W-1:0];
                    w_wdata = r_walk[SP_W-1:0];
                    n_walk  = r_walk + 1'b1;
                    n_sp    = r_walk + 1'b1;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_ALLOC_RD: begin
                if (r_sp == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_sp    = r_sp - 1'b1;
                    w_raddr = SP_W'(r_sp - 1'b1);
                    n_state = ST_ALLOC_WAIT;
                end
            end
            ST_ALLOC_WAIT: begin
                n_idx      = IDX_W'(w_rdata);
                w_bm_set   = 1'b1;
                w_bm_bits  = WORD_W'(1) << w_rdata[BIT_W-1:0];
                w_mdu_ctrl.start_mul = 1'b1;
                w_mdu_a    = BOFF_W'(w_rdata);
                n_state    = ST_ALLOC_MUL;
            end
            ST_ALLOC_MUL: begin
                if (w_mdu_stat.done) begin
                    n_out.success      = 1'b1;
                    n_out.block_index  = r_idx;
                    n_out.block_offset = w_prod[OFF_W-1:0];
                    n_state            = ST_OUT;
                end
            end
            ST_QUERY_MUL: begin
                if (r_block_size != '0 && r_in.byte_offset < w_end) begin
                    w_mdu_ctrl.start_div = 1'b1;
                    w_mdu_a = r_in.byte_offset;
                    n_state = ST_QUERY_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_QUERY_DIV: begin
                if (w_mdu_stat.done) begin
                    n_state = ST_QUERY_CHK;
                end
            end
            ST_QUERY_CHK: begin
                if (w_rem == '0 && w_quot < BOFF_W'(MAX_BLOCKS)) begin
                    n_out.success = r_bitmap[W_W'(w_quot >> BIT_W)][w_quot[BIT_W-1:0]];
                end
                n_state = ST_OUT;
            end
            ST_SWEEP_RD: begin
                n_fmask   = w_cur_word & ~r_in.alive_mask & w_valid_mask;
                w_bm_and  = w_word_ok;
                w_bm_bits = w_cur_word & ~r_in.alive_mask & w_valid_mask;
                n_state   = ST_SWEEP_SCAN;
            end
            ST_SWEEP_SCAN: begin
                if (r_walk == CNT_W'(WORD_W)) begin
                    n_out.freed_mask = r_fmask;
                    n_state          = ST_OUT;
                end else begin
                    // count every freed bit, push while the stack has room
                    if (r_fmask[r_walk[BIT_W-1:0]]) begin
                        n_out.free_total = r_out.free_total + 1'b1;
                        if (r_sp < CNT_W'(MAX_BLOCKS)) begin
                            w_we    = 1'b1;
                            w_wdata = SP_W'(w_push_idx);
                            n_sp    = r_sp + 1'b1;
                        end
                    end
                    n_walk = r_walk + 1'b1;
                end
            end
            ST_OUT: begin
                n_out.full_res  = (r_sp == '0);
                n_out.empty_res = !w_any_use;
                n_out_valid     = 1'b1;
                n_state         = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CNT_W'(MAX_BLOCKS))
        else $error("free stack overflow");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_OUT))
        else $error("result raised outside output step");
    a_alloc_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALLOC_RD && r_sp != '0) |=> r_sp == $past(r_sp) - 1'b1)
        else $error("allocate did not pop");
`endif
endmodule
